// ===== sv/quoted_string_escape_decoder_assert.svh =====
// Assertion macros shared by the quoted string escape decoder RTL.
`ifndef QUOTED_STRING_ESCAPE_DECODER_ASSERT_SVH
`define QUOTED_STRING_ESCAPE_DECODER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define QSED_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("%m: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define QSED_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

// ===== sv/qsed_pkg.sv =====
// Types, constants and helper functions of the quoted string escape decoder.
`default_nettype none

package qsed_pkg;

    // Scan phases of the string parser.
    typedef enum logic [3:0] {
        PH_IDLE     = 4'd0,
        PH_NORMAL   = 4'd1,
        PH_ESC      = 4'd2,
        PH_OCT1     = 4'd3,
        PH_OCT2     = 4'd4,
        PH_CTL      = 4'd5,
        PH_BIGC     = 4'd6,
        PH_META     = 4'd7,
        PH_METADASH = 4'd8,
        PH_MESC     = 4'd9,
        PH_MESCC    = 4'd10,
        PH_MCTL     = 4'd11
    } phase_t;

    // Status codes reported with every result.
    typedef enum logic [2:0] {
        ST_SCAN    = 3'd0,
        ST_CLOSED  = 3'd1,
        ST_BADESC  = 3'd2,
        ST_UNTERM  = 3'd3,
        ST_NOQUOTE = 3'd4
    } status_t;

    // Character constants.
    localparam logic [7:0] CHR_DQUOTE = 8'h22;
    localparam logic [7:0] CHR_SQUOTE = 8'h27;
    localparam logic [7:0] CHR_BSLASH = 8'h5C;
    localparam logic [7:0] CHR_DASH   = 8'h2D;
    localparam logic [7:0] CHR_ZERO   = 8'h30;
    localparam logic [7:0] CHR_SEVEN  = 8'h37;
    localparam logic [7:0] CHR_AT     = 8'h40;
    localparam logic [7:0] CHR_US     = 8'h5F;
    localparam logic [7:0] CHR_LC_A   = 8'h61;
    localparam logic [7:0] CHR_LC_Z   = 8'h7A;
    localparam logic [7:0] CHR_LC_C   = 8'h63;
    localparam logic [7:0] CHR_UC_C   = 8'h43;
    localparam logic [7:0] CHR_UC_M   = 8'h4D;
    localparam logic [7:0] CHR_NUL    = 8'h00;
    localparam logic [7:0] META_BIT   = 8'h80;
    localparam logic [7:0] CASE_SHIFT = 8'h20;

    // One input character.
    typedef struct packed {
        logic       buffer_end;
        logic [7:0] char_byte;
    } item_t;

    // One decoded result.
    typedef struct packed {
        logic       byte_valid;
        logic [7:0] decoded_byte;
        status_t    status;
    } result_t;

    // Single-letter escapes: returns {hit, value}.
    function automatic logic [8:0] simple_escape(input logic [7:0] c);
        logic [8:0] r;
        r = 9'd0;
        unique case (c)
            8'h61:   r = {1'b1, 8'h07};  // a
            8'h62:   r = {1'b1, 8'h08};  // b
            8'h74:   r = {1'b1, 8'h09};  // t
            8'h6E:   r = {1'b1, 8'h0A};  // n
            8'h76:   r = {1'b1, 8'h0B};  // v
            8'h66:   r = {1'b1, 8'h0C};  // f
            8'h72:   r = {1'b1, 8'h0D};  // r
            8'h73:   r = {1'b1, 8'h20};  // s
            default: r = 9'd0;
        endcase
        return r;
    endfunction

    // Upper-cases a lower-case letter, leaves other bytes alone.
    function automatic logic [7:0] upcase(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= CHR_LC_A && c <= CHR_LC_Z) begin
            r = c - CASE_SHIFT;
        end
        return r;
    endfunction

    function automatic logic is_octal(input logic [7:0] c);
        return (c >= CHR_ZERO) && (c <= CHR_SEVEN);
    endfunction

    function automatic logic is_ctl_letter(input logic [7:0] c);
        return (c >= CHR_AT) && (c <= CHR_US);
    endfunction

endpackage

`default_nettype wire

// ===== sv/quoted_string_escape_decoder.sv =====
// Top level of the quoted string escape decoder.
//
// The slave stream carries one text character per beat in s_tdata[7:0]; s_tlast
// marks the end of the text buffer, and on such a beat the character is ignored.
// The master stream returns exactly one result beat for every input beat:
// m_tuser is set when m_tdata[7:0] carries a decoded string byte, and
// m_tdata[10:8] gives the status (scanning, closed, bad escape, unterminated,
// no opening quote). While idle, a quote opens a string; after any ending the
// parser is idle again and waits for the next opening quote.
// An input beat passes the input register, then the decode logic into the result
// register, which drives its result beat. Throughput is one beat per cycle while
// the receiver does not stall.
// A synchronous active-low reset empties both register stages and returns the
// parser to idle. When the receiver stalls, the result register holds its beat,
// the input register keeps one more character, and s_tready then drops until
// m_tready is seen again; no beat is lost or repeated.
`default_nettype none

module quoted_string_escape_decoder
    import qsed_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] char_byte
    input  wire logic        s_tlast,   // buffer_end
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // [7:0] decoded_byte, [10:8] status, [15:11] zero
    output logic             m_tuser    // byte_valid
);

    item_t   s_item;
    item_t   item;
    logic    item_valid;
    logic    out_ready;
    logic    consume;
    result_t dec_result;
    result_t m_result;

    assign s_item.char_byte  = s_tdata;
    assign s_item.buffer_end = s_tlast;

    // A character is consumed when the result register can take its beat.
    assign consume = item_valid && out_ready;

    qsed_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_tvalid),
        .s_ready    (s_tready),
        .s_item     (s_item),
        .advance    (out_ready),
        .item_valid (item_valid),
        .item       (item)
    );

    qsed_decode u_decode (
        .aclk    (aclk),
        .aresetn (aresetn),
        .consume (consume),
        .item    (item),
        .result  (dec_result)
    );

    qsed_out_reg u_out_reg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (item_valid),
        .in_ready  (out_ready),
        .in_result (dec_result),
        .m_valid   (m_tvalid),
        .m_ready   (m_tready),
        .m_result  (m_result)
    );

    // Pack the result beat.
    assign m_tdata = {5'd0, m_result.status, m_result.decoded_byte};
    assign m_tuser = m_result.byte_valid;

endmodule

`default_nettype wire

// ===== sv/qsed_in_reg.sv =====
// Input register stage: holds one accepted character until the decoder consumes it.
`default_nettype none

module qsed_in_reg
    import qsed_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  s_valid,
    output logic       s_ready,
    input  wire item_t s_item,
    input  wire logic  advance,
    output logic       item_valid,
    output item_t      item
);

    logic  valid_reg, valid_next;
    item_t item_reg;

    // Accept whenever the stage is empty or its item moves on this cycle.
    assign s_ready    = !valid_reg || advance;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb begin
        valid_next = valid_reg;
        if (s_ready) begin
            valid_next = s_valid;
        end
    end

    // Valid flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Payload needs no reset.
    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            item_reg <= s_item;
        end
    end

endmodule

`default_nettype wire

// ===== sv/qsed_decode.sv =====
// Parser state and per-character decode logic of the escape decoder.
`default_nettype none

module qsed_decode
    import qsed_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  consume,
    input  wire item_t item,
    output result_t    result
);

`include "quoted_string_escape_decoder_assert.svh"

    phase_t     phase_reg, phase_next;
    logic       dquote_reg, dquote_next;
    logic [5:0] octal_reg, octal_next;

    logic [7:0] c;
    logic [7:0] delim;
    logic [7:0] up;
    logic [8:0] simple;

    assign c      = item.char_byte;
    assign delim  = dquote_reg ? CHR_DQUOTE : CHR_SQUOTE;
    assign up     = upcase(c);
    assign simple = simple_escape(c);

    // Next state and result for the character at hand.
    always_comb begin
        phase_next          = phase_reg;
        dquote_next         = dquote_reg;
        octal_next          = octal_reg;
        result.byte_valid   = 1'b0;
        result.decoded_byte = 8'd0;
        result.status       = ST_SCAN;

        if (phase_reg == PH_IDLE) begin
            if (!item.buffer_end && (c == CHR_DQUOTE || c == CHR_SQUOTE)) begin
                dquote_next = (c == CHR_DQUOTE);
                phase_next  = PH_NORMAL;
            end else begin
                result.status = ST_NOQUOTE;
            end
        end else if (item.buffer_end) begin
            result.status = ST_UNTERM;
            phase_next    = PH_IDLE;
        end else begin
            unique case (phase_reg)
                PH_NORMAL: begin
                    priority if (c == delim) begin
                        result.status = ST_CLOSED;
                        phase_next    = PH_IDLE;
                    end else if (c == CHR_BSLASH) begin
                        phase_next = PH_ESC;
                    end else begin
                        result.byte_valid   = 1'b1;
                        result.decoded_byte = c;
                    end
                end
                PH_ESC: begin
                    phase_next = PH_NORMAL;
                    priority if (c == delim) begin
                        result.byte_valid   = 1'b1;
                        result.decoded_byte = c;
                    end else if (c == CHR_NUL) begin
                        result.byte_valid   = 1'b1;
                        result.decoded_byte = 8'd0;
                    end else if (simple[8]) begin
                        result.byte_valid   = 1'b1;
                        result.decoded_byte = simple[7:0];
                    end else if (is_octal(c)) begin
                        octal_next = {3'd0, c[2:0]};
                        phase_next = PH_OCT1;
                    end else if (c == CHR_LC_C) begin
                        phase_next = PH_CTL;
                    end else if (c == CHR_UC_C) begin
                        phase_next = PH_BIGC;
                    end else if (c == CHR_UC_M) begin
                        phase_next = PH_META;
                    end else begin
                        result.status = ST_BADESC;
                        phase_next    = PH_IDLE;
                    end
                end
                PH_OCT1: begin
                    if (is_octal(c)) begin
                        octal_next = {octal_reg[2:0], c[2:0]};
                        phase_next = PH_OCT2;
                    end else begin
                        result.status = ST_BADESC;
                        phase_next    = PH_IDLE;
                    end
                end
                PH_OCT2: begin
                    if (is_octal(c)) begin
                        // Three digits truncated to one byte.
                        result.byte_valid   = 1'b1;
                        result.decoded_byte = {octal_reg[4:0], c[2:0]};
                        phase_next          = PH_NORMAL;
                    end else begin
                        result.status = ST_BADESC;
                        phase_next    = PH_IDLE;
                    end
                end
                PH_CTL, PH_MCTL: begin
                    if (is_ctl_letter(up)) begin
                        // Subtracting '@' from a letter in '@'..'_' keeps the low five bits.
                        result.byte_valid   = 1'b1;
                        result.decoded_byte = {3'd0, up[4:0]};
                        if (phase_reg == PH_MCTL) begin
                            result.decoded_byte = {3'd0, up[4:0]} | META_BIT;
                        end
                        phase_next = PH_NORMAL;
                    end else begin
                        result.status = ST_BADESC;
                        phase_next    = PH_IDLE;
                    end
                end
                PH_BIGC, PH_META, PH_MESCC: begin
                    if (c == CHR_DASH) begin
                        priority if (phase_reg == PH_BIGC) begin
                            phase_next = PH_CTL;
                        end else if (phase_reg == PH_META) begin
                            phase_next = PH_METADASH;
                        end else begin
                            phase_next = PH_MCTL;
                        end
                    end else begin
                        result.status = ST_BADESC;
                        phase_next    = PH_IDLE;
                    end
                end
                PH_METADASH: begin
                    if (c == CHR_BSLASH) begin
                        phase_next = PH_MESC;
                    end else begin
                        result.byte_valid   = 1'b1;
                        result.decoded_byte = c | META_BIT;
                        phase_next          = PH_NORMAL;
                    end
                end
                PH_MESC: begin
                    if (c == CHR_UC_C) begin
                        phase_next = PH_MESCC;
                    end else begin
                        result.status = ST_BADESC;
                        phase_next    = PH_IDLE;
                    end
                end
                default: begin
                    result.status = ST_BADESC;
                    phase_next    = PH_IDLE;
                end
            endcase
        end
    end

    // Parser state advances only when a character is consumed.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_IDLE;
            dquote_reg <= 1'b0;
            octal_reg  <= 6'd0;
        end else if (consume) begin
            phase_reg  <= phase_next;
            dquote_reg <= dquote_next;
            octal_reg  <= octal_next;
        end
    end

    // A decoded byte is only ever reported while the string is still open.
    `QSED_ASSERT_NOW(a_byte_only_scanning, aclk, aresetn,
        consume && result.byte_valid, result.status == ST_SCAN)
    // Any ending status sends the parser back to idle.
    `QSED_ASSERT_NEXT(a_end_goes_idle, aclk, aresetn,
        consume && result.status != ST_SCAN && result.status != ST_NOQUOTE,
        phase_reg == PH_IDLE)
    // End of buffer inside a string reports unterminated.
    `QSED_ASSERT_NOW(a_end_unterm, aclk, aresetn,
        consume && item.buffer_end && phase_reg != PH_IDLE,
        result.status == ST_UNTERM && !result.byte_valid)

endmodule

`default_nettype wire

// ===== sv/qsed_out_reg.sv =====
// Result register stage: holds one decoded beat until the receiver takes it.
`default_nettype none

module qsed_out_reg
    import qsed_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    in_valid,
    output logic         in_ready,
    input  wire result_t in_result,
    output logic         m_valid,
    input  wire logic    m_ready,
    output result_t      m_result
);

    logic    valid_reg, valid_next;
    result_t result_reg;

    // Load whenever the register is empty or drained this cycle.
    assign in_ready = !valid_reg || m_ready;
    assign m_valid  = valid_reg;
    assign m_result = result_reg;

    always_comb begin
        valid_next = valid_reg;
        if (in_ready) begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            result_reg <= in_result;
        end
    end

endmodule

`default_nettype wire
